FILE: rtl/core/assert_macros.svh
// assertion macros shared by the cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LKSC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lksc assertion failed");

// condition must never be seen outside reset
`define LKSC_ASSERT_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("lksc forbidden condition seen");

`endif

FILE: rtl/core/lksc_pkg.sv
// types and constants of the lru key slot cache
package lksc_pkg;

   localparam int ENTRIES_DEF  = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int KEY_W        = 32;
   localparam int TGT_W        = 4;
   localparam int SLOT_OUT_W   = 4;

   typedef enum logic [1:0] {
      OP_LOOKUP        = 2'd0,
      OP_LOOKUP_INSERT = 2'd1,
      OP_DEMOTE        = 2'd2,
      OP_FLUSH         = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 operation;
      logic [KEY_W-1:0]       key;
      logic [TGT_W-1:0]       target_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0]  slot;
      logic                   found;
      logic                   hit;
      logic                   inserted;
      logic                   evicted;
      logic [KEY_W-1:0]       evicted_key;
      logic                   full_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RANK_RD,
      ST_RANK_CAP,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic key_we;
      logic rank_we;
      logic occ_set;
      logic occ_clr_all;
   } store_ctl_type;

endpackage

FILE: rtl/core/lksc_store.sv
// slot storage: key memory, recency rank memory and occupied flags
module lksc_store #(
   parameter int ENTRIES  = lksc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lksc_pkg::KEY_BITS_DEF,
   localparam int SLOT_W  = $clog2(ENTRIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lksc_pkg::store_ctl_type ctl,
   input  logic [SLOT_W-1:0]       key_raddr,
   input  logic [SLOT_W-1:0]       key_waddr,
   input  logic [KEY_BITS-1:0]     key_wdata,
   input  logic [SLOT_W-1:0]       rank_raddr,
   input  logic [SLOT_W-1:0]       rank_waddr,
   input  logic [SLOT_W-1:0]       rank_wdata,
   input  logic [SLOT_W-1:0]       lru_idx,
   output logic [KEY_BITS-1:0]     key_rdata,
   output logic                    occ_rdata,
   output logic [SLOT_W-1:0]       rank_rdata,
   output logic                    occ_lru
);

   logic [KEY_BITS-1:0] key_mem_ff [ENTRIES];
   logic [SLOT_W-1:0]   rank_mem_ff [ENTRIES];
   logic [ENTRIES-1:0]  rank_vld_ff;
   logic [ENTRIES-1:0]  occ_ff;
   logic [KEY_BITS-1:0] key_rdata_ff;
   logic                occ_rdata_ff;
   logic [SLOT_W-1:0]   rank_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem_ff[key_waddr] <= key_wdata;
      end
      key_rdata_ff <= key_mem_ff[key_raddr];
      occ_rdata_ff <= occ_ff[key_raddr];
   end

   // a rank never written reads as its reset value, the slot index
   always_ff @(posedge clock) begin
      if (ctl.rank_we) begin
         rank_mem_ff[rank_waddr] <= rank_wdata;
      end
      rank_rdata_ff <= rank_vld_ff[rank_raddr] ? rank_mem_ff[rank_raddr] : rank_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_vld_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (ctl.rank_we) begin
            rank_vld_ff[rank_waddr] <= 1'b1;
         end
         if (ctl.occ_clr_all) begin
            occ_ff <= '0;
         end else if (ctl.occ_set) begin
            occ_ff[key_waddr] <= 1'b1;
         end
      end
   end

   assign key_rdata  = key_rdata_ff;
   assign occ_rdata  = occ_rdata_ff;
   assign rank_rdata = rank_rdata_ff;
   assign occ_lru    = occ_ff[lru_idx];

endmodule

FILE: rtl/core/lru_key_slot_cache.sv
// lru key slot cache top level: request sequencer, scan and recency update
// a lookup scans keys (SCAN), then DECIDE, and on hit or insert sweeps ranks (UPDATE);
// a demote runs RANK_RD, RANK_CAP, UPDATE; a flush goes to DONE; one request at a time, next
// accept once the result loads; one read port per slot memory and one key compare
// reset: all slots empty, slot k at recency position k, key storage undefined;
// no clearing pass, the block takes requests in the first cycle after reset
`include "assert_macros.svh"

module lru_key_slot_cache #(
   parameter int ENTRIES  = lksc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lksc_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lksc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lksc_pkg::rsp_type rsp_payload
);

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W  = SLOT_W + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0]  SWEEP_END = CNT_W'(ENTRIES);

   // sequencer and request capture
   lksc_pkg::state_type state_ff, state_in;
   lksc_pkg::req_type   req_ff;
   logic                accept;

   // sweep counter and read stage (index of the data coming out of the memories)
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                issuing;
   logic                rd_vld_ff;
   logic [SLOT_W-1:0]   rd_idx_ff;

   // selected slot and its recency rank
   logic                match_ff;
   logic [SLOT_W-1:0]   sel_slot_ff;
   logic [SLOT_W-1:0]   sel_rank_ff;
   logic                promote_ff;
   logic [SLOT_W-1:0]   lru_ff;
   logic [KEY_BITS-1:0] victim_key_ff;
   logic                hit_ff;
   logic                ins_ff;
   logic                evict_ff;

   // result register
   lksc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_load;

   // store interface
   lksc_pkg::store_ctl_type store_ctl;
   logic [SLOT_W-1:0]   rank_raddr;
   logic [SLOT_W-1:0]   rank_new;
   logic [KEY_BITS-1:0] key_rdata;
   logic                occ_rdata;
   logic [SLOT_W-1:0]   rank_rdata;
   logic                occ_lru;

   // width adaptation of the fixed port fields
   logic [KEY_BITS+lksc_pkg::KEY_W-1:0]    req_key_wide;
   logic [KEY_BITS-1:0]                    req_key_k;
   logic [SLOT_W+lksc_pkg::TGT_W-1:0]      tgt_wide;
   logic [SLOT_W-1:0]                      tgt_slot;
   logic                                   in_tgt_ok;
   logic [SLOT_W+lksc_pkg::SLOT_OUT_W-1:0] slot_wide;
   logic [KEY_BITS+lksc_pkg::KEY_W-1:0]    victim_wide;
   logic                                   key_eq;
   logic                                   last_rd;

   assign req_key_wide = {{KEY_BITS{1'b0}}, req_ff.key};
   assign req_key_k    = req_key_wide[KEY_BITS-1:0];
   assign tgt_wide     = {{SLOT_W{1'b0}}, req_ff.target_slot};
   assign tgt_slot     = tgt_wide[SLOT_W-1:0];
   assign in_tgt_ok    = int'(req_payload.target_slot) < ENTRIES;
   assign slot_wide    = {{lksc_pkg::SLOT_OUT_W{1'b0}}, sel_slot_ff};
   assign victim_wide  = {{lksc_pkg::KEY_W{1'b0}}, victim_key_ff};

   assign req_ready = (state_ff == lksc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issuing   = ((state_ff == lksc_pkg::ST_SCAN) || (state_ff == lksc_pkg::ST_UPDATE))
                      && (idx_ff != SWEEP_END);
   assign last_rd   = rd_vld_ff && (rd_idx_ff == LAST_SLOT);

   // key equality compare while scanning
   assign key_eq = occ_rdata && (key_rdata == req_key_k);

   // rank adjust while updating the recency order
   always_comb begin
      rank_new = rank_rdata;
      if (promote_ff) begin
         if (rd_idx_ff == sel_slot_ff) begin
            rank_new = LAST_SLOT;
         end else if (rank_rdata > sel_rank_ff) begin
            rank_new = rank_rdata - SLOT_W'(1);
         end
      end else begin
         if (rd_idx_ff == sel_slot_ff) begin
            rank_new = '0;
         end else if (rank_rdata < sel_rank_ff) begin
            rank_new = rank_rdata + SLOT_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lksc_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.operation)
                  lksc_pkg::OP_LOOKUP,
                  lksc_pkg::OP_LOOKUP_INSERT: state_in = lksc_pkg::ST_SCAN;
                  lksc_pkg::OP_DEMOTE: begin
                     state_in = in_tgt_ok ? lksc_pkg::ST_RANK_RD : lksc_pkg::ST_DONE;
                  end
                  default: state_in = lksc_pkg::ST_DONE;
               endcase
            end
         end
         lksc_pkg::ST_SCAN: begin
            if (last_rd) begin
               state_in = lksc_pkg::ST_DECIDE;
            end
         end
         lksc_pkg::ST_DECIDE: begin
            if (match_ff || (req_ff.operation == lksc_pkg::OP_LOOKUP_INSERT)) begin
               state_in = lksc_pkg::ST_UPDATE;
            end else begin
               state_in = lksc_pkg::ST_DONE;
            end
         end
         lksc_pkg::ST_RANK_RD:  state_in = lksc_pkg::ST_RANK_CAP;
         lksc_pkg::ST_RANK_CAP: state_in = lksc_pkg::ST_UPDATE;
         lksc_pkg::ST_UPDATE: begin
            if (last_rd) begin
               state_in = lksc_pkg::ST_DONE;
            end
         end
         lksc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = lksc_pkg::ST_IDLE;
            end
         end
         default: state_in = lksc_pkg::ST_IDLE;
      endcase
   end

   // store control, sweep counter and result build
   always_comb begin
      store_ctl             = '0;
      store_ctl.occ_clr_all = accept && (req_payload.operation == lksc_pkg::OP_FLUSH);
      store_ctl.rank_we     = (state_ff == lksc_pkg::ST_UPDATE) && rd_vld_ff;
      if ((state_ff == lksc_pkg::ST_DECIDE) && !match_ff
          && (req_ff.operation == lksc_pkg::OP_LOOKUP_INSERT)) begin
         store_ctl.key_we  = 1'b1;
         store_ctl.occ_set = 1'b1;
      end

      rank_raddr = (state_ff == lksc_pkg::ST_RANK_RD) ? tgt_slot : idx_ff[SLOT_W-1:0];

      if (issuing) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if ((state_ff == lksc_pkg::ST_SCAN) || (state_ff == lksc_pkg::ST_UPDATE)) begin
         idx_in = idx_ff;
      end else begin
         idx_in = '0;
      end

      rsp_load             = (state_ff == lksc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      rsp_in.found         = hit_ff || ins_ff;
      rsp_in.slot          = rsp_in.found ? slot_wide[lksc_pkg::SLOT_OUT_W-1:0] : '0;
      rsp_in.hit           = hit_ff;
      rsp_in.inserted      = ins_ff;
      rsp_in.evicted       = evict_ff;
      rsp_in.evicted_key   = evict_ff ? victim_wide[lksc_pkg::KEY_W-1:0] : '0;
      rsp_in.full_res      = occ_lru;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lksc_pkg::ST_IDLE;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         lru_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= issuing;
         // the least recent slot moves only when the old one is promoted or a demote lands
         if (store_ctl.rank_we && (rank_new == '0)) begin
            lru_ff <= rd_idx_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[SLOT_W-1:0];
      if (accept) begin
         req_ff   <= req_payload;
         match_ff <= 1'b0;
         hit_ff   <= 1'b0;
         ins_ff   <= 1'b0;
         evict_ff <= 1'b0;
      end
      if ((state_ff == lksc_pkg::ST_SCAN) && rd_vld_ff) begin
         if (key_eq && !match_ff) begin
            match_ff    <= 1'b1;
            sel_slot_ff <= rd_idx_ff;
            sel_rank_ff <= rank_rdata;
         end
         // keep the key of the current victim in case this turns into an insert
         if (rd_idx_ff == lru_ff) begin
            victim_key_ff <= key_rdata;
         end
      end
      if (state_ff == lksc_pkg::ST_DECIDE) begin
         promote_ff <= 1'b1;
         if (match_ff) begin
            hit_ff <= 1'b1;
         end else if (req_ff.operation == lksc_pkg::OP_LOOKUP_INSERT) begin
            ins_ff      <= 1'b1;
            evict_ff    <= occ_lru;
            sel_slot_ff <= lru_ff;
            sel_rank_ff <= '0;
         end
      end
      if (state_ff == lksc_pkg::ST_RANK_CAP) begin
         promote_ff  <= 1'b0;
         sel_slot_ff <= tgt_slot;
         sel_rank_ff <= rank_rdata;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   lksc_store #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .key_raddr  (idx_ff[SLOT_W-1:0]),
      .key_waddr  (lru_ff),
      .key_wdata  (req_key_k),
      .rank_raddr (rank_raddr),
      .rank_waddr (rd_idx_ff),
      .rank_wdata (rank_new),
      .lru_idx    (lru_ff),
      .key_rdata  (key_rdata),
      .occ_rdata  (occ_rdata),
      .rank_rdata (rank_rdata),
      .occ_lru    (occ_lru)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LKSC_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready)
   `LKSC_ASSERT(a_found_flags, rsp_valid |-> (rsp_payload.found == (rsp_payload.hit || rsp_payload.inserted)))
   `LKSC_ASSERT_NEVER(a_hit_and_insert, rsp_valid && rsp_payload.hit && rsp_payload.inserted)
   `LKSC_ASSERT(a_evict_needs_insert, rsp_valid && rsp_payload.evicted |-> rsp_payload.inserted)

endmodule
